FILE: sv/aes_pkg.sv
// aes_pkg: shared types, constants, s-box tables and round functions
// used by the aes datapath, controller and top level
package aes_pkg;

    localparam int ROUNDS      = 10;
    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int RND_W       = $clog2(ROUNDS + 1);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS);
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1b;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_req_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } aes_res_t;

    typedef enum logic [1:0] {
        ST_KLOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_RUN
    } aes_state_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             last;
        logic             dec;
        logic             exp_load;
        logic             exp_step;
        logic [RND_W-1:0] rk_idx;
    } aes_cmd_t;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] get_b(input logic [BLOCK_W-1:0] s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            t[BLOCK_W-1-8*i -: 8] = inv ? INV_BOX[get_b(s, i)] : FWD_BOX[get_b(s, i)];
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] row_rotate(input logic [BLOCK_W-1:0] s,
                                                      input logic inv);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[BLOCK_W-1-8*(r*4+c) -: 8] =
                    inv ? get_b(s, r*4 + ((c - r + 4) % 4)) : get_b(s, r*4 + ((c + r) % 4));
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] col_mix(input logic [BLOCK_W-1:0] s,
                                                   input logic inv);
        logic [BLOCK_W-1:0] t;
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] x2, x4, x8, m2, m3, m9, m11, m13, m14;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a0 = get_b(s, ((r + 0) % 4) * 4 + c);
                a1 = get_b(s, ((r + 1) % 4) * 4 + c);
                a2 = get_b(s, ((r + 2) % 4) * 4 + c);
                a3 = get_b(s, ((r + 3) % 4) * 4 + c);
                // coefficient per operand position: fwd 2 3 1 1, inv 14 11 13 9
                x2 = xt(a0); x4 = xt(x2); x8 = xt(x4);
                m2 = x2; m14 = x8 ^ x4 ^ x2;
                x2 = xt(a1); x4 = xt(x2); x8 = xt(x4);
                m3 = x2 ^ a1; m11 = x8 ^ x2 ^ a1;
                x2 = xt(a2); x4 = xt(x2); x8 = xt(x4);
                m13 = x8 ^ x4 ^ a2;
                x2 = xt(a3); x4 = xt(x2); x8 = xt(x4);
                m9 = x8 ^ a3;
                t[BLOCK_W-1-8*(r*4+c) -: 8] =
                    inv ? (m14 ^ m11 ^ m13 ^ m9) : (m2 ^ m3 ^ a2 ^ a3);
            end
        end
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] key_next(input logic [BLOCK_W-1:0] p,
                                                    input logic [7:0] rcon);
        logic [BLOCK_W-1:0] n;
        logic [7:0] v;
        n = '0;
        for (int r = 0; r < 4; r++)
        begin
            v = FWD_BOX[get_b(p, ((r + 1) % 4) * 4 + 3)] ^ get_b(p, r*4);
            if (r == 0)
            begin
                v = v ^ rcon;
            end
            n[BLOCK_W-1-8*(r*4) -: 8] = v;
            for (int c = 1; c < 4; c++)
            begin
                v = v ^ get_b(p, r*4 + c);
                n[BLOCK_W-1-8*(r*4+c) -: 8] = v;
            end
        end
        return n;
    endfunction

endpackage

FILE: sv/aes_dp.sv
// aes_dp: key registers, round key store with expansion unit, shared round unit
// depends on aes_pkg; driven by aes_ctrl commands
module aes_dp
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_idx,
    input  logic [63:0]  cfg_data,
    input  aes_req_t     req,
    input  aes_cmd_t     cmd,
    output logic         done,
    output aes_res_t     result
);

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic [BLOCK_W-1:0] rk_store_reg [ROUNDS+1];
    logic [BLOCK_W-1:0] kexp_reg, kexp_next;
    logic [7:0]         rcon_reg;
    logic [BLOCK_W-1:0] state_reg, state_next;
    logic [BLOCK_W-1:0] rk;
    logic [BLOCK_W-1:0] enc_t, dec_t;
    logic               done_reg;
    aes_res_t           result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            rcon_reg     <= RCON_INIT;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == CFG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_we && cfg_idx == CFG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
            if (cmd.exp_load)
            begin
                rcon_reg <= RCON_INIT;
            end
            else if (cmd.exp_step)
            begin
                rcon_reg <= xt(rcon_reg);
            end
            done_reg <= cmd.step && cmd.last;
        end
    end

    assign kexp_next = cmd.exp_load ? {key_high_reg, key_low_reg} : key_next(kexp_reg, rcon_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.exp_load || cmd.exp_step)
        begin
            kexp_reg                 <= kexp_next;
            rk_store_reg[cmd.rk_idx] <= kexp_next;
        end
        if (cmd.load || cmd.step)
        begin
            state_reg <= state_next;
        end
        if (cmd.step && cmd.last)
        begin
            result_reg <= state_next;
        end
    end

    assign rk = rk_store_reg[cmd.rk_idx];

    always_comb
    begin
        enc_t = row_rotate(sbox_layer(state_reg, 1'b0), 1'b0);
        if (!cmd.last)
        begin
            enc_t = col_mix(enc_t, 1'b0);
        end
        enc_t = enc_t ^ rk;
        dec_t = sbox_layer(row_rotate(state_reg, 1'b1), 1'b1) ^ rk;
        if (!cmd.last)
        begin
            dec_t = col_mix(dec_t, 1'b1);
        end
        if (cmd.load)
        begin
            state_next = {req.block_high, req.block_low} ^ rk;
        end
        else
        begin
            state_next = cmd.dec ? dec_t : enc_t;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/aes_ctrl.sv
// aes_ctrl: sequencer for key expansion and the ten cipher rounds
// depends on aes_pkg; issues aes_cmd_t to aes_dp
module aes_ctrl
    import aes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     req_type,
    input  logic     key_wr,
    output logic     busy,
    output aes_cmd_t cmd
);

    aes_state_t       state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic             dec_reg, dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_KLOAD;
            cnt_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dec_reg   <= dec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        case (state_reg)
            ST_KLOAD:
            begin
                state_next = key_wr ? ST_KLOAD : ST_EXPAND;
                cnt_next   = RND_W'(1);
            end
            ST_EXPAND:
            begin
                cnt_next = cnt_reg + RND_W'(1);
                if (key_wr)
                begin
                    state_next = ST_KLOAD;
                end
                else if (cnt_reg == LAST_RND)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (key_wr)
                begin
                    state_next = ST_KLOAD;
                end
                else if (start)
                begin
                    state_next = ST_RUN;
                    cnt_next   = RND_W'(1);
                    dec_next   = req_type;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + RND_W'(1);
                if (cnt_reg == LAST_RND)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_KLOAD:
            begin
                cmd.exp_load = 1'b1;
            end
            ST_EXPAND:
            begin
                cmd.exp_step = 1'b1;
                cmd.rk_idx   = cnt_reg;
            end
            ST_IDLE:
            begin
                busy     = key_wr;
                cmd.load = start && !key_wr;
                cmd.rk_idx = req_type ? LAST_RND : '0;
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                cmd.dec    = dec_reg;
                cmd.last   = cnt_reg == LAST_RND;
                cmd.rk_idx = dec_reg ? LAST_RND - cnt_reg : cnt_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/aes128_block_cipher.sv
// aes128_block_cipher: aes-128 encrypt/decrypt core with writable key
// depends on aes_pkg, aes_ctrl, aes_dp
//
//  channel  | handshake        | payload
//  request  | start / busy     | req (aes_req_t)
//  result   | done (strobe)    | result (aes_res_t)
//  config   | cfg_we           | cfg_idx, cfg_data
//
// a request is loaded with round key 0 or 10 in the accepting cycle, then runs ten
// rounds with busy high; done strobes in the cycle after the last round
// a key write raises busy in its own cycle; busy holds as round keys 0 to 10 are built
// a key write during expansion restarts it; after reset the zero key is expanded first
// results cannot be stalled; done lasts exactly one cycle
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  aes_req_t    req,
    output logic        done,
    output aes_res_t    result,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [63:0] cfg_data
);

    aes_cmd_t cmd;

    aes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .key_wr   (cfg_we),
        .busy     (busy),
        .cmd      (cmd)
    );

    aes_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req),
        .cmd      (cmd),
        .done     (done),
        .result   (result)
    );

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but core not busy");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.step) && $past(cmd.last))
        else $error("result strobe without a final round");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_key_expand: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && !cmd.step |=> busy && cmd.exp_load)
        else $error("key write did not start expansion");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for aes128_block_cipher, encrypt and decrypt
// predicts every result with its own aes-128 model and key schedule
// depends on aes_pkg and the aes128_block_cipher rtl
`timescale 1ns / 100ps

module tb_top
    import aes_pkg::*;
();

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    aes_req_t    req;
    logic        done;
    aes_res_t    result;
    logic        cfg_we;
    logic        cfg_idx;
    logic [63:0] cfg_data;

    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic [127:0] round_keys [11];
    aes_res_t     pending_results [$];
    int           errs;
    int           cycles;
    bit           gaps_on;

    aes128_block_cipher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = dbl(a);
        end
        return p;
    endfunction

    function automatic logic [127:0] subst_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inv ? INV_BOX[byte_at(s, i)] : FWD_BOX[byte_at(s, i)];
        return t;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[127-8*(r*4+c) -: 8] = inv ? byte_at(s, r*4 + ((c - r + 4) & 3))
                                            : byte_at(s, r*4 + ((c + r) & 3));
        return t;
    endfunction

    function automatic logic [7:0] mix_coef(input logic inv, input int k);
        logic [7:0] fm [4];
        logic [7:0] im [4];
        fm = '{8'd2, 8'd3, 8'd1, 8'd1};
        im = '{8'd14, 8'd11, 8'd13, 8'd9};
        return inv ? im[k] : fm[k];
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   acc;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc = acc ^ gf_mul(byte_at(s, j*4 + c), mix_coef(inv, (j - r + 4) & 3));
                t[127-8*(r*4+c) -: 8] = acc;
            end
        return t;
    endfunction

    task automatic expand_keys();
        logic [127:0] p;
        logic [127:0] n;
        logic [7:0]   rc;
        round_keys[0] = {key_hi, key_lo};
        rc = 8'h01;
        for (int k = 1; k <= 10; k++)
        begin
            p = round_keys[k-1];
            for (int r = 0; r < 4; r++)
                n[127-8*(r*4) -: 8] = FWD_BOX[byte_at(p, ((r + 1) & 3)*4 + 3)] ^ byte_at(p, r*4);
            n[127 -: 8] = n[127 -: 8] ^ rc;
            for (int c = 1; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    n[127-8*(r*4+c) -: 8] = byte_at(p, r*4 + c) ^ byte_at(n, r*4 + c - 1);
            round_keys[k] = n;
            rc = dbl(rc);
        end
    endtask

    function automatic aes_res_t predict_cipher(input aes_req_t r);
        logic [127:0] s;
        aes_res_t     o;
        s = {r.block_high, r.block_low};
        if (r.req_type == OP_ENC)
        begin
            s = s ^ round_keys[0];
            for (int k = 1; k < 10; k++)
                s = mix_state(rotate_rows(subst_state(s, 1'b0), 1'b0), 1'b0) ^ round_keys[k];
            s = rotate_rows(subst_state(s, 1'b0), 1'b0) ^ round_keys[10];
        end
        else
        begin
            s = s ^ round_keys[10];
            for (int k = 9; k > 0; k--)
                s = mix_state(subst_state(rotate_rows(s, 1'b1), 1'b1) ^ round_keys[k], 1'b1);
            s = subst_state(rotate_rows(s, 1'b1), 1'b1) ^ round_keys[0];
        end
        o.result_high = s[127:64];
        o.result_low  = s[63:0];
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        aes_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h %h", result.result_high, result.result_low);
                errs++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_high !== want.result_high)
                begin
                    $error("result_high expected %h actual %h", want.result_high,
                           result.result_high);
                    errs++;
                end
                if (result.result_low !== want.result_low)
                begin
                    $error("result_low expected %h actual %h", want.result_low,
                           result.result_low);
                    errs++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        aes_req_t r;
        r.req_type   = op;
        r.block_high = hi;
        r.block_low  = lo;
        while (gaps_on && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_cipher(r));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_HIGH)
            key_hi = val;
        else
            key_lo = val;
        expand_keys();
        // wait for the re-expansion to finish
        while (!busy)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_reset_key();
        send_block(OP_ENC, 64'h0, 64'h0);
        send_block(OP_DEC, 64'h0, 64'h0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '1, '1);
        drain();
    endtask

    task automatic test_known_vector();
        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(OP_ENC, 64'h8000000000000000, 64'h0000000000000001);
        send_block(OP_DEC, 64'h0000000000000001, 64'h8000000000000000);
        drain();
    endtask

    task automatic test_extreme_keys();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        send_block(OP_ENC, 64'h0, 64'h0);
        send_block(OP_DEC, 64'h0, 64'h0);
        send_block(OP_ENC, '1, '1);
        send_block(OP_DEC, '1, '1);
        write_key(CFG_KEY_HIGH, 64'h0);
        send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(OP_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        write_key(CFG_KEY_LOW, 64'h0);
        send_block(OP_ENC, '1, 64'h0);
        send_block(OP_DEC, 64'h0, '1);
        drain();
    endtask

    task automatic test_random_keys();
        for (int ph = 0; ph < 10; ph++)
        begin
            write_key(CFG_KEY_HIGH, rand64());
            write_key(CFG_KEY_LOW, rand64());
            gaps_on = (ph != 3);
            for (int i = 0; i < 150; i++)
            begin
                send_block(1'($urandom_range(1)), rand64(), rand64());
                if (ph == 5 && i == 75)
                    drain();
            end
        end
        gaps_on = 1'b1;
        drain();
    endtask

    task automatic test_round_trip();
        logic [63:0] hi;
        logic [63:0] lo;
        aes_res_t    c;
        aes_req_t    r;
        for (int i = 0; i < 20; i++)
        begin
            hi = rand64();
            lo = rand64();
            r.req_type   = OP_ENC;
            r.block_high = hi;
            r.block_low  = lo;
            c = predict_cipher(r);
            send_block(OP_ENC, hi, lo);
            send_block(OP_DEC, c.result_high, c.result_low);
        end
        drain();
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_KEY_HIGH;
        cfg_data = '0;
        errs     = 0;
        cycles   = 0;
        gaps_on  = 1'b1;
        key_hi   = '0;
        key_lo   = '0;
        expand_keys();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_key();
        test_known_vector();
        test_extreme_keys();
        test_random_keys();
        test_round_trip();
        repeat (20) @(posedge clk);
        if (errs == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
